// ----- design/clwc_pkg.sv -----
// Package for the circular list with cursor: sizes, command and status codes,
// and the request and response types of the shared index step unit.
// Used by every module of the block; depends on nothing.
package clwc_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int POS_W      = 4;
  localparam int CMD_W      = 3;
  localparam int STAT_W     = 2;

  localparam int S_TDATA_W  = ((DATA_WIDTH + POS_W + 7) / 8) * 8;
  localparam int M_TDATA_W  = ((DATA_WIDTH + CNT_W + 7) / 8) * 8;
  localparam int M_TUSER_W  = 1 + STAT_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND = 3'd0,
    CMD_REMOVE = 3'd1,
    CMD_FWD    = 3'd2,
    CMD_BWD    = 3'd3,
    CMD_CLEAR  = 3'd4
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_FULL   = 2'd2,
    ST_BADPOS = 2'd3
  } status_e;

  typedef enum logic {
    STEP_FWD = 1'b0,
    STEP_BWD = 1'b1
  } step_op_e;

  typedef struct packed {
    step_op_e         op;
    logic             restart;
    logic [IDX_W-1:0] idx;
    logic [CNT_W-1:0] count;
  } step_req_t;

  typedef struct packed {
    logic [IDX_W-1:0] next_idx;
    logic             wrap;
  } step_rsp_t;

endpackage

// ----- design/clwc_store.sv -----
// Word store of the ring: one write port and one read port with registered
// read data. Depends on clwc_pkg for its depth and word width.
module clwc_store (
  input  logic                           clk_i,
  input  logic                           we_i,
  input  logic [clwc_pkg::IDX_W-1:0]     waddr_i,
  input  logic [clwc_pkg::DATA_WIDTH-1:0] wdata_i,
  input  logic                           re_i,
  input  logic [clwc_pkg::IDX_W-1:0]     raddr_i,
  output logic [clwc_pkg::DATA_WIDTH-1:0] rdata_o
);
  import clwc_pkg::*;

  logic [DATA_WIDTH-1:0] mem_q [DEPTH];
  logic [DATA_WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/clwc_step_unit.sv -----
// Shared index step unit: wrapping increment or decrement of a ring index
// against the word count, used for cursor moves and the removal shift.
// Depends on clwc_pkg for the request and response types.
module clwc_step_unit (
  input  clwc_pkg::step_req_t req_i,
  output clwc_pkg::step_rsp_t rsp_o
);
  import clwc_pkg::*;

  logic [CNT_W-1:0] inc;
  logic [IDX_W-1:0] last;

  assign inc  = CNT_W'(req_i.idx) + CNT_W'(1);
  assign last = IDX_W'(req_i.count - CNT_W'(1));

  always_comb begin
    rsp_o.wrap = (inc >= req_i.count);
    unique case (req_i.op)
      STEP_FWD: begin
        if (req_i.restart || rsp_o.wrap) begin
          rsp_o.next_idx = '0;
        end else begin
          rsp_o.next_idx = inc[IDX_W-1:0];
        end
      end
      STEP_BWD: begin
        if (req_i.restart || (req_i.idx == '0)) begin
          rsp_o.next_idx = last;
        end else begin
          rsp_o.next_idx = req_i.idx - IDX_W'(1);
        end
      end
      default: rsp_o.next_idx = '0;
    endcase
  end

endmodule

// ----- design/circular_list_with_cursor.sv -----
// Top level of the circular list with cursor: command sequencer, word count,
// cursor and output register. Depends on clwc_pkg, clwc_store, clwc_step_unit.
//
// Usage: each word on the slave stream carries a command in tuser and the
// append word and removal position in tdata. Each command yields exactly one
// word on the master stream with the word under the cursor, the count and a
// status. The block works on one command at a time and drops tready while
// it does so.
// Sequence: an accepted command passes S_EXEC and then S_RESULT, which hands the
// result word to the output register once it is free; cursor steps pass S_STEP_RD
// between the two for the registered read of the word store. A removal shifts
// each word after the removal position down by one, with a read in S_SHIFT_RD
// and a write in S_SHIFT_WR over the single store port pair, before S_RESULT.
// Reset: the word count and cursor are cleared; the store contents are left
// as they are and only entries below the count are ever read.
// Stall: a finished result waits in the output register until it is taken;
// one further command may be accepted and worked on meanwhile, and its
// result waits in the sequencer until the output register frees up.
module circular_list_with_cursor (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // tdata fields from bit 0: data_word[31:0], position[35:32], zero fill.
  input  logic [clwc_pkg::S_TDATA_W-1:0]  s_axis_tdata_i,
  // tuser fields from bit 0: command[2:0].
  input  logic [clwc_pkg::CMD_W-1:0]      s_axis_tuser_i,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // tdata fields from bit 0: cursor_word[31:0], entry_count[36:32], zero fill.
  output logic [clwc_pkg::M_TDATA_W-1:0]  m_axis_tdata_o,
  // tuser fields from bit 0: word_valid[0], status[2:1].
  output logic [clwc_pkg::M_TUSER_W-1:0]  m_axis_tuser_o,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i
);
  import clwc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_STEP_RD,
    S_RESULT
  } state_e;

  state_e                state_q, state_d;
  logic [CMD_W-1:0]      cmd_q, cmd_d;
  logic [DATA_WIDTH-1:0] word_q, word_d;
  logic [POS_W-1:0]      pos_q, pos_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [IDX_W-1:0]      cur_q, cur_d;
  logic                  started_q, started_d;
  logic [IDX_W-1:0]      idx_q, idx_d;
  logic [DATA_WIDTH-1:0] res_word_q, res_word_d;
  logic                  res_valid_q, res_valid_d;
  status_e               res_status_q, res_status_d;
  logic                  m_valid_q, m_valid_d;
  logic [DATA_WIDTH-1:0] m_word_q, m_word_d;
  logic                  m_wvalid_q, m_wvalid_d;
  logic [CNT_W-1:0]      m_count_q, m_count_d;
  status_e               m_status_q, m_status_d;

  logic                  mem_we;
  logic [IDX_W-1:0]      mem_waddr;
  logic [DATA_WIDTH-1:0] mem_wdata;
  logic                  mem_re;
  logic [IDX_W-1:0]      mem_raddr;
  logic [DATA_WIDTH-1:0] mem_rdata;

  step_req_t step_req;
  step_rsp_t step_rsp;

  logic s_accept;
  logic out_free;

  clwc_store u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  clwc_step_unit u_step (
    .req_i (step_req),
    .rsp_o (step_rsp)
  );

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !m_valid_q || m_axis_tready_i;

  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    word_d       = word_q;
    pos_d        = pos_q;
    count_d      = count_q;
    cur_d        = cur_q;
    started_d    = started_q;
    idx_d        = idx_q;
    res_word_d   = res_word_q;
    res_valid_d  = res_valid_q;
    res_status_d = res_status_q;
    m_valid_d    = m_valid_q && !m_axis_tready_i;
    m_word_d     = m_word_q;
    m_wvalid_d   = m_wvalid_q;
    m_count_d    = m_count_q;
    m_status_d   = m_status_q;

    mem_we    = 1'b0;
    mem_waddr = idx_q;
    mem_wdata = mem_rdata;
    mem_re    = 1'b0;
    mem_raddr = step_rsp.next_idx;

    step_req.op      = STEP_FWD;
    step_req.restart = 1'b0;
    step_req.idx     = idx_q;
    step_req.count   = count_q;
    if (state_q == S_EXEC) begin
      step_req.op      = (cmd_e'(cmd_q) == CMD_BWD) ? STEP_BWD : STEP_FWD;
      step_req.restart = !started_q || (CNT_W'(cur_q) >= count_q);
      step_req.idx     = cur_q;
    end

    unique case (state_q)
      S_IDLE: begin
        if (s_accept) begin
          cmd_d   = s_axis_tuser_i;
          word_d  = s_axis_tdata_i[DATA_WIDTH-1:0];
          pos_d   = s_axis_tdata_i[DATA_WIDTH+POS_W-1:DATA_WIDTH];
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        res_word_d   = '0;
        res_valid_d  = 1'b0;
        res_status_d = ST_OK;
        state_d      = S_RESULT;
        unique case (cmd_e'(cmd_q))
          CMD_APPEND: begin
            if (count_q == CNT_W'(DEPTH)) begin
              res_status_d = ST_FULL;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = count_q[IDX_W-1:0];
              mem_wdata = word_q;
              count_d   = count_q + CNT_W'(1);
            end
          end
          CMD_REMOVE: begin
            if (count_q == '0) begin
              res_status_d = ST_EMPTY;
            end else if (CNT_W'(pos_q) >= count_q) begin
              res_status_d = ST_BADPOS;
            end else begin
              idx_d   = IDX_W'(pos_q);
              state_d = S_SHIFT_RD;
            end
          end
          CMD_FWD, CMD_BWD: begin
            if (count_q == '0) begin
              res_status_d = ST_EMPTY;
            end else begin
              cur_d     = step_rsp.next_idx;
              started_d = 1'b1;
              mem_re    = 1'b1;
              state_d   = S_STEP_RD;
            end
          end
          CMD_CLEAR: begin
            cur_d     = '0;
            started_d = 1'b0;
          end
          default: begin
          end
        endcase
      end
      S_SHIFT_RD: begin
        if (step_rsp.wrap) begin
          count_d   = count_q - CNT_W'(1);
          cur_d     = '0;
          started_d = 1'b0;
          state_d   = S_RESULT;
        end else begin
          mem_re  = 1'b1;
          state_d = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        mem_we  = 1'b1;
        idx_d   = step_rsp.next_idx;
        state_d = S_SHIFT_RD;
      end
      S_STEP_RD: begin
        res_word_d  = mem_rdata;
        res_valid_d = 1'b1;
        state_d     = S_RESULT;
      end
      S_RESULT: begin
        if (out_free) begin
          m_valid_d  = 1'b1;
          m_word_d   = res_word_q;
          m_wvalid_d = res_valid_q;
          m_count_d  = count_q;
          m_status_d = res_status_q;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      cur_q     <= '0;
      started_q <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      cur_q     <= cur_d;
      started_q <= started_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    word_q       <= word_d;
    pos_q        <= pos_d;
    idx_q        <= idx_d;
    res_word_q   <= res_word_d;
    res_valid_q  <= res_valid_d;
    res_status_q <= res_status_d;
    m_word_q     <= m_word_d;
    m_wvalid_q   <= m_wvalid_d;
    m_count_q    <= m_count_d;
    m_status_q   <= m_status_d;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = M_TDATA_W'({m_count_q, m_word_q});
  assign m_axis_tuser_o  = {m_status_q, m_wvalid_q};

`ifndef ASSERT_OFF
  a_accept_starts_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept |=> (state_q == S_EXEC))
    else $error("Accepted command did not start execution.");

  a_cursor_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    started_q |-> (CNT_W'(cur_q) < count_q))
    else $error("Started cursor points beyond the stored words.");

  a_remove_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHIFT_RD && step_rsp.wrap) |=> (count_q == $past(count_q) - CNT_W'(1)))
    else $error("Completed removal did not reduce the count by one.");

  a_invalid_word_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && !m_wvalid_q) |-> (m_word_q == '0))
    else $error("Result without a valid word carries a nonzero word.");
`endif

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking bench for circular_list_with_cursor: drives command words, predicts each reply.
// A directed table comes first and random traffic follows, with random stalls on both streams.
// Depends on clwc_pkg and the circular_list_with_cursor RTL.
module tb_top;
  import clwc_pkg::*;

  localparam int LIMIT_CYCLES = 1000000;
  localparam int RANDOM_ITEMS = 2000;
  localparam int LONG_HOLD    = 200;
  localparam int DRAIN_CYCLES = 100;
  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] cursor_word;
    logic                  word_valid;
    logic [CNT_W-1:0]      entry_count;
    status_e               status;
  } reply_t;

  typedef struct packed {
    logic [CMD_W-1:0]      cmd;
    logic [DATA_WIDTH-1:0] word;
    logic [POS_W-1:0]      pos;
    int                    reps;
    bit                    typed;
    reply_t                reply;
  } stim_row_t;

  localparam reply_t NO_REPLY = '{32'd0, 1'b0, 5'd0, ST_OK};

  logic                 clk_i;
  logic                 rst_ni;
  logic [S_TDATA_W-1:0] s_axis_tdata_i;
  logic [CMD_W-1:0]     s_axis_tuser_i;
  logic                 s_axis_tvalid_i;
  logic                 s_axis_tready_o;
  logic [M_TDATA_W-1:0] m_axis_tdata_o;
  logic [M_TUSER_W-1:0] m_axis_tuser_o;
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i;

  circular_list_with_cursor dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i)
  );

  logic [DATA_WIDTH-1:0] ring_mem [DEPTH] = '{default: '0};
  int                    ring_count  = 0;
  int                    cursor_pos  = 0;
  bit                    cursor_live = 1'b0;

  reply_t    pending_replies [$];
  stim_row_t directed_rows [25];
  int        error_count  = 0;
  int        cycle_count  = 0;
  bit        send_burst   = 1'b0;
  bit        hold_pending = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic reply_t ring_predict(logic [CMD_W-1:0] cmd, logic [DATA_WIDTH-1:0] word,
                                          logic [POS_W-1:0] pos);
    reply_t r;
    int     i;
    r = NO_REPLY;
    case (cmd)
      CMD_APPEND: begin
        if (ring_count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          ring_mem[ring_count] = word;
          ring_count++;
        end
      end
      CMD_REMOVE: begin
        if (ring_count == 0) begin
          r.status = ST_EMPTY;
        end else if (int'(pos) >= ring_count) begin
          r.status = ST_BADPOS;
        end else begin
          for (i = int'(pos); i < ring_count - 1; i++) ring_mem[i] = ring_mem[i+1];
          ring_count--;
          cursor_pos  = 0;
          cursor_live = 1'b0;
        end
      end
      CMD_FWD, CMD_BWD: begin
        if (ring_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          if (!cursor_live || cursor_pos >= ring_count) begin
            cursor_pos = (cmd == CMD_FWD) ? 0 : ring_count - 1;
          end else if (cmd == CMD_FWD) begin
            cursor_pos = (cursor_pos + 1 >= ring_count) ? 0 : cursor_pos + 1;
          end else begin
            cursor_pos = (cursor_pos == 0) ? ring_count - 1 : cursor_pos - 1;
          end
          cursor_live   = 1'b1;
          r.cursor_word = ring_mem[cursor_pos];
          r.word_valid  = 1'b1;
        end
      end
      CMD_CLEAR: begin
        cursor_pos  = 0;
        cursor_live = 1'b0;
      end
      default: ;
    endcase
    r.entry_count = CNT_W'(ring_count);
    return r;
  endfunction

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic issue_command(logic [CMD_W-1:0] cmd, logic [DATA_WIDTH-1:0] word,
                               logic [POS_W-1:0] pos, bit typed, reply_t typed_reply);
    int     gap;
    reply_t predicted;
    gap = send_burst ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= S_TDATA_W'({pos, word});
    s_axis_tuser_i  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready_o);
    predicted = ring_predict(cmd, word, pos);
    pending_replies.push_back(typed ? typed_reply : predicted);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (pending_replies.size() != 0);
    @(negedge clk_i);
  endtask

  task automatic check_reply();
    reply_t got;
    reply_t want;
    got.cursor_word = m_axis_tdata_o[DATA_WIDTH-1:0];
    got.entry_count = m_axis_tdata_o[DATA_WIDTH +: CNT_W];
    got.word_valid  = m_axis_tuser_o[0];
    got.status      = status_e'(m_axis_tuser_o[1 +: STAT_W]);
    if (pending_replies.size() == 0) begin
      $error("result word with no command outstanding");
      error_count++;
      return;
    end
    want = pending_replies.pop_front();
    if (got.cursor_word !== want.cursor_word) begin
      $error("cursor_word: expected %h, got %h", want.cursor_word, got.cursor_word);
      error_count++;
    end
    if (got.word_valid !== want.word_valid) begin
      $error("word_valid: expected %0d, got %0d", want.word_valid, got.word_valid);
      error_count++;
    end
    if (got.entry_count !== want.entry_count) begin
      $error("entry_count: expected %0d, got %0d", want.entry_count, got.entry_count);
      error_count++;
    end
    if (got.status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, got.status);
      error_count++;
    end
  endtask

  // Result side: random stalls per word, bursts without stalls, and one long hold.
  initial begin
    int gap;
    int taken;
    bit burst;
    taken = 0;
    burst = 1'b0;
    m_axis_tready_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (taken % 50 == 0) burst = ($urandom_range(0, 3) == 0);
      if (hold_pending) begin
        m_axis_tready_i <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk_i);
        hold_pending = 1'b0;
      end else begin
        gap = burst ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
          m_axis_tready_i <= 1'b0;
          repeat (gap) @(negedge clk_i);
        end
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
      check_reply();
      taken++;
    end
  end

  initial begin
    int               n;
    int               k;
    int               r;
    int               add_pct;
    int               rem_pct;
    int               step_pct;
    logic [CMD_W-1:0] cmd;
    logic [POS_W-1:0] pos;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = '0;

    directed_rows = '{
      '{CMD_FWD,      32'h0,        4'd0,  1, 1'b1, '{32'h0, 1'b0, 5'd0, ST_EMPTY}},
      '{CMD_BWD,      32'h0,        4'd0,  1, 1'b1, '{32'h0, 1'b0, 5'd0, ST_EMPTY}},
      '{CMD_REMOVE,   32'h0,        4'd0,  1, 1'b1, '{32'h0, 1'b0, 5'd0, ST_EMPTY}},
      '{CMD_REMOVE,   32'h0,        4'd15, 1, 1'b1, '{32'h0, 1'b0, 5'd0, ST_EMPTY}},
      '{CMD_CLEAR,    32'h0,        4'd0,  1, 1'b1, '{32'h0, 1'b0, 5'd0, ST_OK}},
      '{CMD_SPARE_HI, 32'hFFFFFFFF, 4'd15, 1, 1'b1, '{32'h0, 1'b0, 5'd0, ST_OK}},
      '{CMD_APPEND,   32'hFFFFFFFF, 4'd0,  1, 1'b1, '{32'h0, 1'b0, 5'd1, ST_OK}},
      '{CMD_FWD,      32'h0,        4'd0,  1, 1'b1, '{32'hFFFFFFFF, 1'b1, 5'd1, ST_OK}},
      '{CMD_FWD,      32'h0,        4'd0,  1, 1'b1, '{32'hFFFFFFFF, 1'b1, 5'd1, ST_OK}},
      '{CMD_BWD,      32'h0,        4'd0,  1, 1'b1, '{32'hFFFFFFFF, 1'b1, 5'd1, ST_OK}},
      '{CMD_REMOVE,   32'h0,        4'd15, 1, 1'b1, '{32'h0, 1'b0, 5'd1, ST_BADPOS}},
      '{CMD_REMOVE,   32'h0,        4'd1,  1, 1'b1, '{32'h0, 1'b0, 5'd1, ST_BADPOS}},
      '{CMD_APPEND,   32'h00000000, 4'd0,  1, 1'b0, NO_REPLY},
      '{CMD_APPEND,   32'h5A5A0000, 4'd0, 14, 1'b0, NO_REPLY},
      '{CMD_APPEND,   32'h12345678, 4'd0,  1, 1'b1, '{32'h0, 1'b0, 5'd16, ST_FULL}},
      '{CMD_BWD,      32'h0,        4'd0,  1, 1'b0, NO_REPLY},
      '{CMD_FWD,      32'h0,        4'd0,  1, 1'b0, NO_REPLY},
      '{CMD_REMOVE,   32'h0,        4'd15, 1, 1'b0, NO_REPLY},
      '{CMD_FWD,      32'h0,        4'd0,  1, 1'b0, NO_REPLY},
      '{CMD_REMOVE,   32'h0,        4'd0,  1, 1'b0, NO_REPLY},
      '{CMD_SPARE_LO, 32'h0,        4'd0,  1, 1'b0, NO_REPLY},
      '{CMD_BWD,      32'h0,        4'd0,  1, 1'b0, NO_REPLY},
      '{CMD_CLEAR,    32'h0,        4'd0,  1, 1'b0, NO_REPLY},
      '{CMD_BWD,      32'h0,        4'd0,  1, 1'b0, NO_REPLY},
      '{CMD_REMOVE,   32'h0,        4'd14, 1, 1'b1, '{32'h0, 1'b0, 5'd14, ST_BADPOS}}
    };

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i]) begin
      for (k = 0; k < directed_rows[i].reps; k++) begin
        issue_command(directed_rows[i].cmd, directed_rows[i].word + k, directed_rows[i].pos,
                      directed_rows[i].typed, directed_rows[i].reply);
      end
    end

    // The mix moves between filling, draining and balanced traffic so that
    // the ring keeps passing through empty, partly filled and full.
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      case ((n / 250) % 3)
        0:       begin add_pct = 60; rem_pct = 10; end
        1:       begin add_pct = 10; rem_pct = 50; end
        default: begin add_pct = 30; rem_pct = 20; end
      endcase
      step_pct = 100 - add_pct - rem_pct - 8;
      if (n % 64 == 0) send_burst = ($urandom_range(0, 3) == 0);
      if (n == 500) hold_pending = 1'b1;
      if (n == 1200) wait_drained();
      r = $urandom_range(0, 99);
      if (r < add_pct) begin
        cmd = CMD_APPEND;
      end else if (r < add_pct + rem_pct) begin
        cmd = CMD_REMOVE;
      end else if (r < add_pct + rem_pct + step_pct / 2) begin
        cmd = CMD_FWD;
      end else if (r < add_pct + rem_pct + step_pct) begin
        cmd = CMD_BWD;
      end else if (r < 96) begin
        cmd = CMD_CLEAR;
      end else begin
        cmd = CMD_W'($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO));
      end
      if (ring_count > 0 && $urandom_range(0, 99) < 85) begin
        pos = POS_W'($urandom_range(0, ring_count - 1));
      end else begin
        pos = POS_W'($urandom_range(0, 15));
      end
      issue_command(cmd, $urandom, pos, 1'b0, NO_REPLY);
    end

    s_axis_tvalid_i <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/clwc_pkg.sv
design/clwc_store.sv
design/clwc_step_unit.sv
design/circular_list_with_cursor.sv
bench/tb_top.sv
